/* src/mstt_pkg.sv */
// types and constants shared by the timer slot table
// payload structs of both channels, the slot word held in ram, codes and sequencer states
// no dependencies
package mstt_pkg;

    localparam logic [1:0] FUNC_ADD  = 2'd0;
    localparam logic [1:0] FUNC_DEL  = 2'd1;
    localparam logic [1:0] FUNC_TICK = 2'd2;
    localparam logic [1:0] FUNC_BAD  = 2'd3;

    localparam logic [2:0] ST_DONE    = 3'd0;
    localparam logic [2:0] ST_REJECT  = 3'd1;
    localparam logic [2:0] ST_MISSING = 3'd2;
    localparam logic [2:0] ST_FIRED   = 3'd3;
    localparam logic [2:0] ST_NONE    = 3'd4;

    localparam logic [9:0] UNIT_K0_MS = 10'd250;
    localparam logic [9:0] UNIT_K1_MS = 10'd1000;

    typedef struct packed {
        logic [1:0]  func;
        logic        handler_kind;
        logic [31:0] handler_tag;
        logic [15:0] interval_count;
        logic        start_now;
        logic        single_shot;
        logic [31:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  slot_index;
        logic [31:0] fired_tag;
        logic        fired_kind;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [31:0] tag;
        logic [31:0] stamp;
        logic [31:0] period;
        logic        single;
    } slot_word_t;

    localparam int SLOT_WORD_W = $bits(slot_word_t);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT,
        S_FLUSH,
        S_REPLY
    } state_t;

endpackage

/* src/mstt_chan_if.sv */
// valid/ready channel carrying one payload struct per transaction
// payload type set per instance; used with types from mstt_pkg
interface mstt_chan_if #(parameter type payload_t = logic);

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);

endinterface

/* src/mstt_ram.sv */
// generic single write port, single read port ram with registered read data
// no dependencies
module mstt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        clk,
    input  logic                                        wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                            wr_data,
    input  logic                                        rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/multi_slot_callback_timer_table.sv */
// top level of the timer slot table: sequencer, slot flags and result register
// depends on mstt_pkg, mstt_chan_if and mstt_ram
//
// cmd carries add, delete and tick requests; res carries the results. each side
// is a valid/ready channel and a transaction completes when both are high.
// cmd is ready only while the sequencer is idle. one request is handled at a
// time: the slots are read one a cycle, unless the walk pauses, from the slot ram and checked by one
// shared compare unit, so every add, delete or tick walks all SLOTS slots.
// add and delete give one result from the commit state after the walk, and cmd is
// ready again once the sequencer is back in idle.
// a rejected request (tag zero or unknown func) gives its result from the reply
// state without a walk. a tick gives one
// result per fired slot in slot order, the last flagged, or one nothing-fired
// result; its final result comes from the flush state after the walk.
// a fired result is held back one slot so that the last flag can be set; when
// res stalls and a second slot fires, the walk pauses until the held result
// moves into the output register. the output register lets a new request be
// accepted while the previous result still waits on res.
// reset clears the used and kind flags of every slot at once; tag, stamp,
// period and oneshot words live in ram and are read for every slot on each walk.
module multi_slot_callback_timer_table #(
    parameter int SLOTS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    mstt_chan_if.sink   cmd,
    mstt_chan_if.source res
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    mstt_pkg::state_t    state_reg, state_next;
    mstt_pkg::in_item_t  item_reg, item_next;
    logic [31:0]         period_reg, period_next;
    logic [CNT_W-1:0]    rd_cnt_reg, rd_cnt_next;
    logic                ev_valid_reg, ev_valid_next;
    logic [IDX_W-1:0]    ev_idx_reg, ev_idx_next;
    logic                match_found_reg, match_found_next;
    logic [IDX_W-1:0]    match_idx_reg, match_idx_next;
    logic                free_found_reg, free_found_next;
    logic [IDX_W-1:0]    free_idx_reg, free_idx_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]    pend_idx_reg, pend_idx_next;
    logic [31:0]         pend_tag_reg, pend_tag_next;
    logic                pend_kind_reg, pend_kind_next;
    logic                out_valid_reg, out_valid_next;
    mstt_pkg::out_item_t out_data_reg, out_data_next;

    logic used_reg [SLOTS];
    logic kind_reg [SLOTS];

    logic                ram_wr_en;
    logic [IDX_W-1:0]    ram_wr_addr;
    logic [mstt_pkg::SLOT_WORD_W-1:0] ram_wr_data;
    logic                ram_rd_en;
    logic [IDX_W-1:0]    ram_rd_addr;
    logic [mstt_pkg::SLOT_WORD_W-1:0] ram_rd_data;

    mstt_pkg::slot_word_t rd_word;
    mstt_pkg::slot_word_t wr_word;
    logic                 used_clr;
    logic                 used_set;
    logic [IDX_W-1:0]     upd_idx;
    logic                 cmd_ready;
    logic                 out_free;
    logic                 is_tick;
    logic                 is_add;
    logic                 ev_used;
    logic                 ev_kind;
    logic [31:0]          limit;
    logic                 fire;
    logic                 stall;
    logic                 scan_done;
    logic [IDX_W-1:0]     add_idx;

    function automatic mstt_pkg::out_item_t make_result(
        input logic [2:0]  status,
        input logic [3:0]  idx,
        input logic [31:0] tag,
        input logic        kind,
        input logic        last
    );
        mstt_pkg::out_item_t r;
        r.status     = status;
        r.slot_index = idx;
        r.fired_tag  = tag;
        r.fired_kind = kind;
        r.last       = last;
        return r;
    endfunction

    mstt_ram #(
        .WIDTH (mstt_pkg::SLOT_WORD_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // shared compare unit on the slot under evaluation
    assign rd_word   = mstt_pkg::slot_word_t'(ram_rd_data);
    assign ev_used   = used_reg[ev_idx_reg];
    assign ev_kind   = kind_reg[ev_idx_reg];
    assign limit     = rd_word.stamp + rd_word.period;
    assign is_tick   = (item_reg.func == mstt_pkg::FUNC_TICK);
    assign is_add    = (item_reg.func == mstt_pkg::FUNC_ADD);
    assign fire      = ev_valid_reg && is_tick && ev_used
                       && ((item_reg.now_ms < rd_word.stamp) || (item_reg.now_ms > limit));
    assign out_free  = !out_valid_reg || res.ready;
    assign stall     = fire && pend_valid_reg && !out_free;
    assign scan_done = (rd_cnt_reg == CNT_W'(SLOTS)) && !ev_valid_reg;
    assign add_idx   = match_found_reg ? match_idx_reg : free_idx_reg;
    assign ram_wr_data = wr_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= mstt_pkg::S_IDLE;
            rd_cnt_reg      <= '0;
            ev_valid_reg    <= 1'b0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            pend_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            rd_cnt_reg      <= rd_cnt_next;
            ev_valid_reg    <= ev_valid_next;
            match_found_reg <= match_found_next;
            free_found_reg  <= free_found_next;
            pend_valid_reg  <= pend_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        period_reg    <= period_next;
        ev_idx_reg    <= ev_idx_next;
        match_idx_reg <= match_idx_next;
        free_idx_reg  <= free_idx_next;
        pend_idx_reg  <= pend_idx_next;
        pend_tag_reg  <= pend_tag_next;
        pend_kind_reg <= pend_kind_next;
        out_data_reg  <= out_data_next;
    end

    // slot flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                used_reg[i] <= 1'b0;
                kind_reg[i] <= 1'b0;
            end
        end
        else if (used_set)
        begin
            used_reg[upd_idx] <= 1'b1;
            kind_reg[upd_idx] <= item_reg.handler_kind;
        end
        else if (used_clr)
        begin
            used_reg[upd_idx] <= 1'b0;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        item_next        = item_reg;
        period_next      = period_reg;
        rd_cnt_next      = rd_cnt_reg;
        ev_valid_next    = ev_valid_reg;
        ev_idx_next      = ev_idx_reg;
        match_found_next = match_found_reg;
        match_idx_next   = match_idx_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        pend_valid_next  = pend_valid_reg;
        pend_idx_next    = pend_idx_reg;
        pend_tag_next    = pend_tag_reg;
        pend_kind_next   = pend_kind_reg;
        out_valid_next   = out_valid_reg && !res.ready;
        out_data_next    = out_data_reg;
        ram_rd_en        = 1'b0;
        ram_rd_addr      = rd_cnt_reg[IDX_W-1:0];
        ram_wr_en        = 1'b0;
        ram_wr_addr      = ev_idx_reg;
        wr_word          = rd_word;
        wr_word.stamp    = item_reg.now_ms;
        used_clr         = 1'b0;
        used_set         = 1'b0;
        upd_idx          = ev_idx_reg;
        cmd_ready        = 1'b0;

        unique case (state_reg)
            mstt_pkg::S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd.valid)
                begin
                    item_next        = cmd.data;
                    period_next      = 32'(cmd.data.interval_count)
                                       * 32'(cmd.data.handler_kind ? mstt_pkg::UNIT_K1_MS
                                                                   : mstt_pkg::UNIT_K0_MS);
                    rd_cnt_next      = '0;
                    ev_valid_next    = 1'b0;
                    match_found_next = 1'b0;
                    free_found_next  = 1'b0;
                    pend_valid_next  = 1'b0;
                    if (cmd.data.func == mstt_pkg::FUNC_TICK)
                    begin
                        state_next = mstt_pkg::S_SCAN;
                    end
                    else if ((cmd.data.func == mstt_pkg::FUNC_BAD)
                             || (cmd.data.handler_tag == 32'd0))
                    begin
                        state_next = mstt_pkg::S_REPLY;
                    end
                    else
                    begin
                        state_next = mstt_pkg::S_SCAN;
                    end
                end
            end

            mstt_pkg::S_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = is_tick ? mstt_pkg::S_FLUSH : mstt_pkg::S_COMMIT;
                end
                else if (!stall)
                begin
                    if (rd_cnt_reg != CNT_W'(SLOTS))
                    begin
                        ram_rd_en     = 1'b1;
                        rd_cnt_next   = rd_cnt_reg + CNT_W'(1);
                        ev_valid_next = 1'b1;
                        ev_idx_next   = rd_cnt_reg[IDX_W-1:0];
                    end
                    else
                    begin
                        ev_valid_next = 1'b0;
                    end

                    if (ev_valid_reg)
                    begin
                        if (is_tick)
                        begin
                            if (fire)
                            begin
                                // earlier fired slot leaves, this one is held for the last flag
                                if (pend_valid_reg)
                                begin
                                    out_valid_next = 1'b1;
                                    out_data_next  = make_result(mstt_pkg::ST_FIRED,
                                                                 4'(pend_idx_reg), pend_tag_reg,
                                                                 pend_kind_reg, 1'b0);
                                end
                                pend_valid_next = 1'b1;
                                pend_idx_next   = ev_idx_reg;
                                pend_tag_next   = rd_word.tag;
                                pend_kind_next  = ev_kind;
                                if (rd_word.single)
                                begin
                                    used_clr = 1'b1;
                                end
                                else
                                begin
                                    ram_wr_en = 1'b1;
                                end
                            end
                        end
                        else
                        begin
                            if (!match_found_reg && ev_used
                                && (rd_word.tag == item_reg.handler_tag)
                                && (ev_kind == item_reg.handler_kind))
                            begin
                                match_found_next = 1'b1;
                                match_idx_next   = ev_idx_reg;
                            end
                            if (!free_found_reg && !ev_used)
                            begin
                                free_found_next = 1'b1;
                                free_idx_next   = ev_idx_reg;
                            end
                        end
                    end
                end
            end

            mstt_pkg::S_COMMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = mstt_pkg::S_IDLE;
                    if (is_add)
                    begin
                        if (match_found_reg || free_found_reg)
                        begin
                            ram_wr_en      = 1'b1;
                            ram_wr_addr    = add_idx;
                            wr_word.tag    = item_reg.handler_tag;
                            wr_word.stamp  = item_reg.start_now ? 32'd0 : item_reg.now_ms;
                            wr_word.period = period_reg;
                            wr_word.single = item_reg.single_shot;
                            used_set       = 1'b1;
                            upd_idx        = add_idx;
                            out_data_next  = make_result(mstt_pkg::ST_DONE, 4'(add_idx),
                                                         32'd0, 1'b0, 1'b1);
                        end
                        else
                        begin
                            out_data_next = make_result(mstt_pkg::ST_REJECT, 4'd0,
                                                        32'd0, 1'b0, 1'b1);
                        end
                    end
                    else
                    begin
                        if (match_found_reg)
                        begin
                            used_clr      = 1'b1;
                            upd_idx       = match_idx_reg;
                            out_data_next = make_result(mstt_pkg::ST_DONE, 4'(match_idx_reg),
                                                        32'd0, 1'b0, 1'b1);
                        end
                        else
                        begin
                            out_data_next = make_result(mstt_pkg::ST_MISSING, 4'd0,
                                                        32'd0, 1'b0, 1'b1);
                        end
                    end
                end
            end

            mstt_pkg::S_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = mstt_pkg::S_IDLE;
                    if (pend_valid_reg)
                    begin
                        out_data_next = make_result(mstt_pkg::ST_FIRED, 4'(pend_idx_reg),
                                                    pend_tag_reg, pend_kind_reg, 1'b1);
                    end
                    else
                    begin
                        out_data_next = make_result(mstt_pkg::ST_NONE, 4'd0,
                                                    32'd0, 1'b0, 1'b1);
                    end
                end
            end

            mstt_pkg::S_REPLY:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = make_result(mstt_pkg::ST_REJECT, 4'd0,
                                                 32'd0, 1'b0, 1'b1);
                    state_next     = mstt_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = mstt_pkg::S_IDLE;
            end
        endcase
    end

    assign cmd.ready = cmd_ready;
    assign res.valid = out_valid_reg;
    assign res.data  = out_data_reg;

    // evaluation stage only carries a slot during a walk
    a_ev_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid_reg |-> (state_reg == mstt_pkg::S_SCAN))
        else $error("slot under evaluation outside a walk");

    // a held fired result exists only while a tick is under way
    a_pend_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (is_tick && ((state_reg == mstt_pkg::S_SCAN)
                                        || (state_reg == mstt_pkg::S_FLUSH))))
        else $error("held fired result outside a tick");

    // only fired results may come without the last flag
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_data_reg.status != mstt_pkg::ST_FIRED)) |-> out_data_reg.last)
        else $error("non-fired result without last flag");

    // read counter never passes the slot count
    a_rd_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        rd_cnt_reg <= CNT_W'(SLOTS))
        else $error("read counter past last slot");

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// self-checking testbench for the timer slot table: directed corner cases, then random traffic
// depends on mstt_pkg, mstt_chan_if and multi_slot_callback_timer_table from src
module tb;

    localparam int NSLOTS = 16;
    localparam int TAG_POOL = 24;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 74;

    class timer_slot_shadow;
        bit          used_at[NSLOTS];
        bit          kind_at[NSLOTS];
        logic [31:0] tag_at[NSLOTS];
        logic [31:0] stamp_at[NSLOTS];
        logic [31:0] period_at[NSLOTS];
        bit          oneshot_at[NSLOTS];
        mstt_pkg::out_item_t due_results[$];
        int unsigned mismatches;

        function new();
            foreach (used_at[i])
            begin
                used_at[i] = 0;
                kind_at[i] = 0;
            end
            mismatches = 0;
        endfunction

        function void apply_request(mstt_pkg::in_item_t rq);
            mstt_pkg::out_item_t r;
            mstt_pkg::out_item_t held;
            bit          have_held;
            int          hit;
            logic [31:0] lim;
            r = '0;
            r.last = 1'b1;
            have_held = 0;
            held = '0;
            hit = -1;
            if (rq.func == mstt_pkg::FUNC_TICK)
            begin
                for (int i = 0; i < NSLOTS; i++)
                begin
                    if (!used_at[i])
                        continue;
                    lim = stamp_at[i] + period_at[i];
                    if (rq.now_ms < stamp_at[i] || rq.now_ms > lim)
                    begin
                        if (have_held)
                            due_results.push_back(held);
                        held = '0;
                        held.status = mstt_pkg::ST_FIRED;
                        held.slot_index = 4'(i);
                        held.fired_tag = tag_at[i];
                        held.fired_kind = kind_at[i];
                        have_held = 1;
                        if (oneshot_at[i])
                            used_at[i] = 0;
                        else
                            stamp_at[i] = rq.now_ms;
                    end
                end
                if (have_held)
                begin
                    held.last = 1'b1;
                    due_results.push_back(held);
                end
                else
                begin
                    r.status = mstt_pkg::ST_NONE;
                    due_results.push_back(r);
                end
                return;
            end
            if (rq.func == mstt_pkg::FUNC_BAD || rq.handler_tag == 32'd0)
            begin
                r.status = mstt_pkg::ST_REJECT;
                due_results.push_back(r);
                return;
            end
            for (int i = 0; i < NSLOTS; i++)
                if (hit < 0 && used_at[i] && tag_at[i] == rq.handler_tag
                    && kind_at[i] == rq.handler_kind)
                    hit = i;
            if (rq.func == mstt_pkg::FUNC_DEL)
            begin
                if (hit < 0)
                    r.status = mstt_pkg::ST_MISSING;
                else
                begin
                    used_at[hit] = 0;
                    r.status = mstt_pkg::ST_DONE;
                    r.slot_index = 4'(hit);
                end
                due_results.push_back(r);
                return;
            end
            for (int i = 0; i < NSLOTS; i++)
                if (hit < 0 && !used_at[i])
                    hit = i;
            if (hit < 0)
            begin
                r.status = mstt_pkg::ST_REJECT;
                due_results.push_back(r);
                return;
            end
            used_at[hit] = 1;
            kind_at[hit] = rq.handler_kind;
            tag_at[hit] = rq.handler_tag;
            stamp_at[hit] = rq.start_now ? 32'd0 : rq.now_ms;
            period_at[hit] = 32'(rq.interval_count)
                * (rq.handler_kind ? 32'(mstt_pkg::UNIT_K1_MS) : 32'(mstt_pkg::UNIT_K0_MS));
            oneshot_at[hit] = rq.single_shot;
            r.status = mstt_pkg::ST_DONE;
            r.slot_index = 4'(hit);
            due_results.push_back(r);
        endfunction

        function void report(string field, logic [31:0] want, logic [31:0] got);
            $display("%0t mismatch on %s: expected %h, got %h", $time, field, want, got);
            mismatches++;
        endfunction

        function void match_result(mstt_pkg::out_item_t got);
            mstt_pkg::out_item_t want;
            if (due_results.size() == 0)
            begin
                $display("%0t unexpected result: expected none, got status %0d slot %0d tag %h",
                         $time, got.status, got.slot_index, got.fired_tag);
                mismatches++;
                return;
            end
            want = due_results.pop_front();
            if (got.status !== want.status)
                report("status", 32'(want.status), 32'(got.status));
            if (got.slot_index !== want.slot_index)
                report("slot_index", 32'(want.slot_index), 32'(got.slot_index));
            if (got.fired_tag !== want.fired_tag)
                report("fired_tag", want.fired_tag, got.fired_tag);
            if (got.fired_kind !== want.fired_kind)
                report("fired_kind", 32'(want.fired_kind), 32'(got.fired_kind));
            if (got.last !== want.last)
                report("last", 32'(want.last), 32'(got.last));
        endfunction
    endclass

    logic clk;
    logic rst_n;

    mstt_chan_if #(.payload_t(mstt_pkg::in_item_t))  cmd_if ();
    mstt_chan_if #(.payload_t(mstt_pkg::out_item_t)) res_if ();

    multi_slot_callback_timer_table #(
        .SLOTS(NSLOTS)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .res   (res_if)
    );

    timer_slot_shadow shadow = new();

    int unsigned send_gap_pct;
    int unsigned stall_pct;
    logic [31:0] clock_ms;
    logic [31:0] tag_pool[TAG_POOL];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("FAILED: results differ");
        $finish;
    end

    always @(negedge clk)
        res_if.ready = ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_if.valid && cmd_if.ready)
                shadow.apply_request(cmd_if.data);
            if (res_if.valid && res_if.ready)
                shadow.match_result(res_if.data);
        end
    end

    function automatic mstt_pkg::in_item_t pack_req(logic [1:0] func, logic kind,
                                                    logic [31:0] tag, logic [15:0] count,
                                                    logic now_flag, logic oneshot,
                                                    logic [31:0] now);
        mstt_pkg::in_item_t rq;
        rq.func = func;
        rq.handler_kind = kind;
        rq.handler_tag = tag;
        rq.interval_count = count;
        rq.start_now = now_flag;
        rq.single_shot = oneshot;
        rq.now_ms = now;
        return rq;
    endfunction

    function automatic mstt_pkg::in_item_t random_request();
        mstt_pkg::in_item_t rq;
        int       pick;
        rq = '0;
        pick = $urandom_range(99);
        if (pick < 40)
            rq.func = mstt_pkg::FUNC_ADD;
        else if (pick < 60)
            rq.func = mstt_pkg::FUNC_DEL;
        else if (pick < 95)
            rq.func = mstt_pkg::FUNC_TICK;
        else
            rq.func = pick[0] ? mstt_pkg::FUNC_BAD : mstt_pkg::FUNC_ADD;
        rq.handler_kind = 1'($urandom_range(1));
        if (pick >= 95)
            rq.handler_tag = pick[0] ? $urandom : 32'd0;
        else if ($urandom_range(19) == 0)
            rq.handler_tag = $urandom;
        else
            rq.handler_tag = tag_pool[$urandom_range(TAG_POOL - 1)];
        if ($urandom_range(4) == 0)
            rq.interval_count = 16'($urandom);
        else
            rq.interval_count = rq.handler_kind ? 16'($urandom_range(3))
                                                : 16'($urandom_range(12));
        rq.start_now = ($urandom_range(7) == 0);
        rq.single_shot = 1'($urandom_range(1));
        case ($urandom_range(49))
            0: clock_ms = $urandom;
            1: clock_ms = clock_ms - 32'($urandom_range(5000));
            default: clock_ms = clock_ms + 32'($urandom_range(600));
        endcase
        rq.now_ms = clock_ms;
        return rq;
    endfunction

    task automatic send_request(input mstt_pkg::in_item_t rq);
        while ($urandom_range(99) < send_gap_pct)
            @(negedge clk);
        cmd_if.valid = 1'b1;
        cmd_if.data = rq;
        do
            @(posedge clk);
        while (!cmd_if.ready);
        @(negedge clk);
        cmd_if.valid = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cmd_if.valid = 1'b0;
        cmd_if.data = '0;
        res_if.ready = 1'b0;
        send_gap_pct = 15;
        stall_pct = 46;
        clock_ms = 32'd5000;
        foreach (tag_pool[i])
        begin
            tag_pool[i] = $urandom;
            if (tag_pool[i] == 32'd0)
                tag_pool[i] = 32'd1;
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty table, rejects and a delete miss
        send_request(pack_req(mstt_pkg::FUNC_TICK, 1'b0, 32'd0, 16'd0, 1'b0, 1'b0, 32'd0));
        send_request(pack_req(mstt_pkg::FUNC_ADD, 1'b0, 32'd0, 16'd5, 1'b0, 1'b0, 32'd100));
        send_request(pack_req(mstt_pkg::FUNC_BAD, 1'b1, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1,
                              32'hFFFF_FFFF));
        send_request(pack_req(mstt_pkg::FUNC_DEL, 1'b1, 32'd0, 16'd0, 1'b0, 1'b0, 32'd0));
        send_request(pack_req(mstt_pkg::FUNC_DEL, 1'b0, 32'h1234_5678, 16'd0, 1'b0, 1'b0,
                              32'd0));
        // same tag in both kinds, widest intervals, stamp-plus-period wrapping
        send_request(pack_req(mstt_pkg::FUNC_ADD, 1'b0, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, 1'b0,
                              32'hFFFF_F000));
        send_request(pack_req(mstt_pkg::FUNC_ADD, 1'b1, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1,
                              32'd0));
        send_request(pack_req(mstt_pkg::FUNC_TICK, 1'b0, 32'd0, 16'd0, 1'b0, 1'b0,
                              32'h0000_0010));
        send_request(pack_req(mstt_pkg::FUNC_ADD, 1'b0, 32'hFFFF_FFFF, 16'd1, 1'b0, 1'b1,
                              32'hFFFF_FFF0));
        send_request(pack_req(mstt_pkg::FUNC_TICK, 1'b0, 32'd0, 16'd0, 1'b0, 1'b0,
                              32'hFFFF_FFFF));
        send_request(pack_req(mstt_pkg::FUNC_DEL, 1'b1, 32'hFFFF_FFFF, 16'd0, 1'b0, 1'b0,
                              32'd0));
        // fill every slot, overflow, then fire them all
        for (int i = 0; i < NSLOTS; i++)
            send_request(pack_req(mstt_pkg::FUNC_ADD, 1'(i), 32'hA5A5_0000 + 32'(i), 16'(i),
                                  1'b1, 1'(i >> 1), 32'd777));
        send_request(pack_req(mstt_pkg::FUNC_ADD, 1'b0, 32'h5A5A_FFFF, 16'd3, 1'b0, 1'b0,
                              32'd777));
        send_request(pack_req(mstt_pkg::FUNC_TICK, 1'b0, 32'd0, 16'd0, 1'b0, 1'b0,
                              32'h8000_0000));

        for (int phase = 0; phase < 3; phase++)
        begin
            send_gap_pct = (phase == 0) ? 15 : (phase == 1) ? 46 : 0;
            stall_pct = (phase == 0) ? 46 : (phase == 1) ? 15 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_request(random_request());
        end

        while (shadow.due_results.size() != 0)
            @(posedge clk);
        repeat (2 * NSLOTS + 8) @(posedge clk);
        if (shadow.mismatches == 0 && shadow.due_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
